// ===== rtl/pbal_pkg.sv =====
// Shared types and constants of the power-of-two bitmap allocator.
package pbal_pkg;

  localparam int WORD_BITS = 64;
  localparam int POS_W     = 6;
  localparam int UNIT_W    = 12;
  localparam int LIMIT_W   = 13;
  localparam int ORDER_W   = 4;
  localparam int SUM_W     = 17;
  localparam int STATUS_W  = 3;
  localparam int REM_W     = 7;
  localparam int SORD_W    = 3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISALIGN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Orders below this fit inside one map word.
  localparam logic [ORDER_W-1:0] WORD_ORDER = 4'd6;

  typedef struct packed {
    logic                 hit;
    logic [POS_W-1:0]     hit_pos;
    logic [WORD_BITS-1:0] hit_mask;
    logic                 pos_set;
    logic [WORD_BITS-1:0] pos_mask;
    logic                 zero;
    logic                 ones;
  } word_res_t;

endpackage

// ===== rtl/pbal_word_unit.sv =====
// Evaluates one map word: lowest free aligned run, run masks and fill tests.
module pbal_word_unit (
  input  logic [pbal_pkg::WORD_BITS-1:0] word,
  input  logic [pbal_pkg::SORD_W-1:0]    ord,
  input  logic [pbal_pkg::POS_W-1:0]     pos,
  input  logic [pbal_pkg::REM_W-1:0]     rem,
  output pbal_pkg::word_res_t            res
);

  logic [pbal_pkg::WORD_BITS-1:0] lvl [0:5];
  logic [pbal_pkg::WORD_BITS-1:0] sel;
  logic [pbal_pkg::WORD_BITS-1:0] cand;
  logic [pbal_pkg::REM_W-1:0]     n;
  logic [pbal_pkg::POS_W-1:0]     hpos;

  // Unit j of the word sits at bit 63-j.
  function automatic logic [pbal_pkg::WORD_BITS-1:0] run_mask(
    input logic [pbal_pkg::POS_W-1:0]  p,
    input logic [pbal_pkg::SORD_W-1:0] o
  );
    logic [6:0]                     cnt;
    logic [6:0]                     sh;
    logic [pbal_pkg::WORD_BITS-1:0] ones;
    cnt  = 7'd1 << o;
    ones = (64'd1 << cnt) - 64'd1;
    sh   = 7'd64 - cnt - {1'b0, p};
    return ones << sh[5:0];
  endfunction

  assign n = 7'd1 << ord;

  // Level m marks positions whose next 2^m units are all free.
  always_comb begin
    for (int j = 0; j < pbal_pkg::WORD_BITS; j++) begin
      lvl[0][j] = ~word[pbal_pkg::WORD_BITS-1-j];
    end
    for (int m = 1; m < 6; m++) begin
      for (int j = 0; j < pbal_pkg::WORD_BITS; j++) begin
        if (j + (1 << (m - 1)) < pbal_pkg::WORD_BITS) begin
          lvl[m][j] = lvl[m-1][j] & lvl[m-1][j + (1 << (m - 1))];
        end else begin
          lvl[m][j] = 1'b0;
        end
      end
    end
  end

  assign sel = (ord <= 3'd5) ? lvl[ord] : '0;

  always_comb begin
    for (int j = 0; j < pbal_pkg::WORD_BITS; j++) begin
      cand[j] = sel[j]
                && ((6'(j) & (n[5:0] - 6'd1)) == 6'd0)
                && ((8'(j) + {1'b0, n}) <= {1'b0, rem});
    end
    hpos = '0;
    for (int j = pbal_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hpos = 6'(j);
      end
    end
  end

  always_comb begin
    res.hit      = |cand;
    res.hit_pos  = hpos;
    res.hit_mask = run_mask(hpos, ord);
    res.pos_mask = run_mask(pos, ord);
    res.pos_set  = (word & res.pos_mask) == res.pos_mask;
    res.zero     = (word == '0);
    res.ones     = (word == '1);
  end

endmodule

// ===== rtl/pow2_bitmap_allocator_core.sv =====
// Top level of the power-of-two bitmap allocator: sequencer, map memory, limit register.
// A request that fails its checks is answered from idle; a small free (order below 6) updates
// one word in evaluate; a small allocate scans words in evaluate; a large request checks its
// block word by word in evaluate, then writes it in fill; one map word moves per cycle.
// Throughput: one request at a time; busy is low again in the cycle of the result beat.
// Reset: synchronous, active low; a clearing pass then writes MAP_WORDS words while busy is high.
module pow2_bitmap_allocator_core #(
  parameter int MAP_UNITS = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [pbal_pkg::ORDER_W-1:0]    in_size_order,
  input  logic [pbal_pkg::UNIT_W-1:0]     in_block_index,
  output logic                            out_valid,
  output logic [pbal_pkg::UNIT_W-1:0]     out_granted_index,
  output logic [pbal_pkg::STATUS_W-1:0]   out_status,
  input  logic                            cfg_wr_en,
  input  logic [pbal_pkg::LIMIT_W-1:0]    cfg_wr_data
);

  localparam int MAP_WORDS = MAP_UNITS / pbal_pkg::WORD_BITS;
  localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [pbal_pkg::SUM_W-1:0] MapUnitsW = pbal_pkg::SUM_W'(MAP_UNITS);
  localparam logic [WAW-1:0] LastWord = WAW'(MAP_WORDS - 1);
  localparam logic [pbal_pkg::SUM_W-1:0] WordStep = 17'd64;

  localparam logic [1:0] SQ_CLEAR = 2'd0;
  localparam logic [1:0] SQ_IDLE  = 2'd1;
  localparam logic [1:0] SQ_EVAL  = 2'd2;
  localparam logic [1:0] SQ_FILL  = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic                            op_r, op_nxt;
  logic [pbal_pkg::ORDER_W-1:0]    order_r, order_nxt;
  logic [pbal_pkg::SUM_W-1:0]      nbits_r, nbits_nxt;
  logic [pbal_pkg::SUM_W-1:0]      blk_r, blk_nxt;
  logic [pbal_pkg::SUM_W-1:0]      cur_r, cur_nxt;
  logic [pbal_pkg::LIMIT_W-1:0]    usable_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [pbal_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [pbal_pkg::UNIT_W-1:0]     out_granted_r, out_granted_nxt;

  logic [pbal_pkg::WORD_BITS-1:0]  map_mem [MAP_WORDS];
  logic [pbal_pkg::WORD_BITS-1:0]  rdata_r;
  logic                            mem_we;
  logic [WAW-1:0]                  mem_waddr;
  logic [pbal_pkg::WORD_BITS-1:0]  mem_wdata;
  logic [pbal_pkg::SUM_W-1:0]      rd_unit;

  logic [pbal_pkg::SUM_W-1:0]      limit;
  logic [pbal_pkg::SUM_W-1:0]      in_nbits;
  logic [pbal_pkg::UNIT_W-1:0]     in_align_mask;
  logic [pbal_pkg::SUM_W-1:0]      in_end;
  logic [pbal_pkg::SUM_W-1:0]      nxt_word;
  logic [pbal_pkg::SUM_W-1:0]      nxt_blk;
  logic                            last_word;
  logic [pbal_pkg::SUM_W-1:0]      rem_full;
  logic [pbal_pkg::REM_W-1:0]      rem;
  logic                            sub_word;
  pbal_pkg::word_res_t             wres;

  assign limit = ({4'd0, usable_r} < MapUnitsW) ? {4'd0, usable_r} : MapUnitsW;

  assign in_nbits      = 17'd1 << in_size_order;
  assign in_align_mask = in_nbits[pbal_pkg::UNIT_W-1:0] - 12'd1;
  assign in_end        = {5'd0, in_block_index} + in_nbits;

  assign nxt_word  = cur_r + WordStep;
  assign nxt_blk   = blk_r + nbits_r;
  assign last_word = nxt_word >= nxt_blk;
  assign rem_full  = limit - cur_r;
  assign rem       = (rem_full > 17'd127) ? 7'd127 : rem_full[pbal_pkg::REM_W-1:0];
  assign sub_word  = order_r < pbal_pkg::WORD_ORDER;

  pbal_word_unit u_word (
    .word (rdata_r),
    .ord  (order_r[pbal_pkg::SORD_W-1:0]),
    .pos  (cur_r[pbal_pkg::POS_W-1:0]),
    .rem  (rem),
    .res  (wres)
  );

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    order_nxt       = order_r;
    nbits_nxt       = nbits_r;
    blk_nxt         = blk_r;
    cur_nxt         = cur_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    mem_we          = 1'b0;
    mem_waddr       = cur_r[6 +: WAW];
    mem_wdata       = '0;
    rd_unit         = cur_r;
    case (state_r)
      SQ_CLEAR: begin
        mem_we = 1'b1;
        if (cur_r[6 +: WAW] == LastWord) begin
          state_nxt = SQ_IDLE;
          cur_nxt   = '0;
        end else begin
          cur_nxt = nxt_word;
        end
      end
      SQ_IDLE: begin
        if (start) begin
          op_nxt          = in_opcode;
          order_nxt       = in_size_order;
          nbits_nxt       = in_nbits;
          out_granted_nxt = '0;
          if (in_opcode == pbal_pkg::OP_ALLOC) begin
            if (in_nbits > limit) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = pbal_pkg::ST_NOSPACE;
            end else begin
              blk_nxt   = '0;
              cur_nxt   = '0;
              rd_unit   = '0;
              state_nxt = SQ_EVAL;
            end
          end else if ((in_block_index & in_align_mask) != '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pbal_pkg::ST_MISALIGN;
          end else if (in_end > limit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pbal_pkg::ST_RANGE;
          end else begin
            blk_nxt   = {5'd0, in_block_index};
            cur_nxt   = {5'd0, in_block_index};
            rd_unit   = {5'd0, in_block_index};
            state_nxt = SQ_EVAL;
          end
        end
      end
      SQ_EVAL: begin
        if (op_r == pbal_pkg::OP_ALLOC && sub_word) begin
          if (wres.hit) begin
            mem_we          = 1'b1;
            mem_wdata       = rdata_r | wres.hit_mask;
            out_valid_nxt   = 1'b1;
            out_status_nxt  = pbal_pkg::ST_OK;
            out_granted_nxt = cur_r[pbal_pkg::UNIT_W-1:0] + {6'd0, wres.hit_pos};
            state_nxt       = SQ_IDLE;
          end else if (nxt_word + nbits_r > limit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pbal_pkg::ST_NOSPACE;
            state_nxt      = SQ_IDLE;
          end else begin
            cur_nxt = nxt_word;
            rd_unit = nxt_word;
          end
        end else if (op_r == pbal_pkg::OP_ALLOC) begin
          if (!wres.zero) begin
            // A taken word sinks the whole block; move on to the next aligned one.
            if (nxt_blk + nbits_r > limit) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = pbal_pkg::ST_NOSPACE;
              state_nxt      = SQ_IDLE;
            end else begin
              blk_nxt = nxt_blk;
              cur_nxt = nxt_blk;
              rd_unit = nxt_blk;
            end
          end else if (last_word) begin
            cur_nxt   = blk_r;
            state_nxt = SQ_FILL;
          end else begin
            cur_nxt = nxt_word;
            rd_unit = nxt_word;
          end
        end else if (sub_word) begin
          out_valid_nxt = 1'b1;
          state_nxt     = SQ_IDLE;
          if (wres.pos_set) begin
            mem_we         = 1'b1;
            mem_wdata      = rdata_r & ~wres.pos_mask;
            out_status_nxt = pbal_pkg::ST_OK;
          end else begin
            out_status_nxt = pbal_pkg::ST_NOTALLOC;
          end
        end else begin
          if (!wres.ones) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pbal_pkg::ST_NOTALLOC;
            state_nxt      = SQ_IDLE;
          end else if (last_word) begin
            cur_nxt   = blk_r;
            state_nxt = SQ_FILL;
          end else begin
            cur_nxt = nxt_word;
            rd_unit = nxt_word;
          end
        end
      end
      SQ_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = (op_r == pbal_pkg::OP_ALLOC) ? '1 : '0;
        if (last_word) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = pbal_pkg::ST_OK;
          out_granted_nxt = (op_r == pbal_pkg::OP_ALLOC) ? blk_r[pbal_pkg::UNIT_W-1:0] : '0;
          state_nxt       = SQ_IDLE;
        end else begin
          cur_nxt = nxt_word;
        end
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= map_mem[rd_unit[6 +: WAW]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_CLEAR;
      cur_r       <= '0;
      usable_r    <= 13'd4096;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        usable_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    order_r       <= order_nxt;
    nbits_r       <= nbits_nxt;
    blk_r         <= blk_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign busy              = (state_r != SQ_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_r;

endmodule
